FILE: design/tlca_pkg.sv
// ----------------------------------------------------------------------------
// Two-line closest approach: shared definitions
// Widths, fixed-point formats and the data carried along the cell chains.
// ----------------------------------------------------------------------------
package tlca_pkg;

	localparam int PW    = 32;            // point and vertex width, 8 fraction bits
	localparam int DW    = 16;            // direction component width
	localparam int FB    = 24;            // line parameter fraction bits
	localparam int UP    = FB - 8;        // alignment shift between points and Q
	localparam int IN_W  = 6 * PW + 6 * DW;
	localparam int OUT_W = 4 * PW;

	localparam int AW    = 2 * DW;        // d.d, never negative
	localparam int CW    = 2 * DW + 1;    // d1.d2, signed
	localparam int RW    = PW + 1;        // P1 - P2
	localparam int EW    = PW + DW + 2;   // R.d
	localparam int EL    = EW / 2;
	localparam int EH    = EW - EL;
	localparam int XW    = CW;
	localparam int YW    = EH + 1;
	localparam int PPW   = XW + YW;
	localparam int DETW  = 4 * DW;        // magnitude of the determinant
	localparam int NW    = PPW + EL + 1;  // numerators of t1 and t2
	localparam int QW    = NW - 1 + UP;   // dividend and quotient magnitude

	localparam int SQIN  = 2 * PW;        // radicand bits fed to the root chain

	typedef struct packed {
		logic [2:0][PW-1:0] p1;
		logic [2:0][DW-1:0] d1;
		logic [2:0][PW-1:0] p2;
		logic [2:0][DW-1:0] d2;
	} lines_t;

	// One slot of the divider chain: both quotients share the divisor.
	typedef struct packed {
		logic            par;
		logic            neg1;
		logic            neg2;
		lines_t          ln;
		logic [DETW-1:0] dvs;
		logic [DETW-1:0] rem1;
		logic [DETW-1:0] rem2;
		logic [QW-1:0]   w1;
		logic [QW-1:0]   w2;
	} div_t;

	// One slot of the square root chain.
	typedef struct packed {
		logic               par;
		logic               sat;
		logic [2:0][PW-1:0] vtx;
		logic [SQIN-1:0]    x;
		logic [PW+1:0]      rem;
		logic [PW-1:0]      root;
	} sqr_t;

	typedef struct packed {
		logic               par;
		logic [PW-1:0]      distance;
		logic [2:0][PW-1:0] vtx;
	} res_t;

endpackage

FILE: design/tlca_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// Produces one quotient bit of both line parameters and hands the slot on.
// ----------------------------------------------------------------------------
module tlca_div_cell import tlca_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vin,
	input  div_t din,
	output logic vout,
	output div_t dout
);

	div_t nxt;
	logic [DETW:0] r1, r2, t1, t2;
	logic          q1, q2;

	always_comb begin
		// The dividend bit shifts out of the top of w while the quotient bit
		// shifts in at the bottom.
		r1 = {din.rem1, din.w1[QW-1]};
		r2 = {din.rem2, din.w2[QW-1]};
		t1 = r1 - {1'b0, din.dvs};
		t2 = r2 - {1'b0, din.dvs};
		q1 = !t1[DETW];
		q2 = !t2[DETW];
		nxt      = din;
		nxt.rem1 = q1 ? t1[DETW-1:0] : r1[DETW-1:0];
		nxt.rem2 = q2 ? t2[DETW-1:0] : r2[DETW-1:0];
		nxt.w1   = {din.w1[QW-2:0], q1};
		nxt.w2   = {din.w2[QW-2:0], q2};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

endmodule

FILE: design/tlca_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// Settles one root bit from two radicand bits and hands the slot on.
// ----------------------------------------------------------------------------
module tlca_sqrt_cell import tlca_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vin,
	input  sqr_t din,
	output logic vout,
	output sqr_t dout
);

	sqr_t          nxt;
	logic [PW+3:0] r, trial;
	logic [PW+4:0] diff;
	logic          ge;

	always_comb begin
		r     = {din.rem, din.x[SQIN-1 -: 2]};
		trial = (PW + 4)'({din.root, 2'b01});
		diff  = {1'b0, r} - {1'b0, trial};
		ge    = !diff[PW+4];
		nxt      = din;
		nxt.rem  = ge ? diff[PW+1:0] : r[PW+1:0];
		nxt.root = {din.root[PW-2:0], ge};
		nxt.x    = {din.x[SQIN-3:0], 2'b00};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

endmodule

FILE: design/two_line_closest_approach_unit.sv
// ----------------------------------------------------------------------------
// Two-line closest approach unit
// Vertex and distance of closest approach for a stream of 3D line pairs.
// ----------------------------------------------------------------------------
// One line pair is taken per clock and one result leaves per clock unless
// back-pressure holds the pipeline. A result passes the dot product and
// numerator stages, a chain of 100 divider cells that each settle one
// quotient bit of both line parameters, the stages that form the closest
// points, the vertex and the squared distance, a chain of 32 root cells, and
// the output register. Back-pressure holds the whole pipeline once a result
// waits in the skid stage behind the output register. Parallel lines give a
// zero vertex, a zero distance and the parallel flag.
module two_line_closest_approach_unit import tlca_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// line1_point_x/y/z, line1_dir_x/y/z, line2_point_x/y/z, line2_dir_x/y/z
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// vertex_x, vertex_y, vertex_z, closest_distance
	output logic [OUT_W-1:0] m_tdata,
	// lines_parallel
	output logic             m_tuser
);

	localparam int TW   = QW + 1;
	localparam int CK   = (TW + 3) / 4;
	localparam int PDW  = CK + 1 + DW;
	localparam int QVW  = TW + DW;
	localparam int QSW  = QVW + 1;
	localparam int VSH  = UP + 1;
	localparam int VQW  = QSW - VSH;
	localparam int DLW  = PW + UP;
	localparam int DLH  = DLW / 2;
	localparam int DHW  = DLW - DLH;
	localparam int SW   = 2 * DLW + 2;

	localparam logic signed [VQW-1:0] VMAX =
		{{(VQW-PW+1){1'b0}}, {(PW-1){1'b1}}};
	localparam logic signed [VQW-1:0] VMIN =
		{{(VQW-PW+1){1'b1}}, {(PW-1){1'b0}}};

	function automatic logic signed [PPW-1:0] mul_xy(input logic signed [XW-1:0] x,
	                                                 input logic signed [YW-1:0] y);
		return x * y;
	endfunction

	function automatic logic signed [YW-1:0] ylo(input logic [EW-1:0] e);
		return YW'({1'b0, e[EL-1:0]});
	endfunction

	function automatic logic signed [YW-1:0] yhi(input logic [EW-1:0] e);
		return YW'($signed(e[EW-1:EL]));
	endfunction

	function automatic logic signed [CK:0] chunk(input logic [TW-1:0] t, input int j);
		logic signed [CK:0] c;
		if (j < 3) begin
			c = {1'b0, t[j*CK +: CK]};
		end else begin
			c = (CK + 1)'($signed(t[TW-1:3*CK]));
		end
		return c;
	endfunction

	logic en;
	logic [4:0] fvld_q;
	logic [8:0] bvld_q;

	// ---------------- stage 1: direction dot products, P1 - P2
	lines_t in_ln;
	logic [AW-1:0]           a_d, b_d;
	logic signed [CW-1:0]    c_d;
	logic signed [AW-1:0]    s11 [3], s22 [3], s12 [3];
	logic signed [RW-1:0]    r_d [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			in_ln.p1[k] = s_tdata[k*PW +: PW];
			in_ln.d1[k] = s_tdata[3*PW + k*DW +: DW];
			in_ln.p2[k] = s_tdata[3*PW + 3*DW + k*PW +: PW];
			in_ln.d2[k] = s_tdata[6*PW + 3*DW + k*DW +: DW];
		end
		for (int k = 0; k < 3; k++) begin
			s11[k] = $signed(in_ln.d1[k]) * $signed(in_ln.d1[k]);
			s22[k] = $signed(in_ln.d2[k]) * $signed(in_ln.d2[k]);
			s12[k] = $signed(in_ln.d1[k]) * $signed(in_ln.d2[k]);
			r_d[k] = RW'($signed(in_ln.p1[k])) - RW'($signed(in_ln.p2[k]));
		end
		a_d = s11[0] + s11[1] + s11[2];
		b_d = s22[0] + s22[1] + s22[2];
		c_d = CW'(s12[0]) + CW'(s12[1]) + CW'(s12[2]);
	end

	lines_t               ln_s1;
	logic [AW-1:0]        a_s1, b_s1;
	logic signed [CW-1:0] c_s1;
	logic signed [RW-1:0] r_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s1 <= in_ln;
			a_s1  <= a_d;
			b_s1  <= b_d;
			c_s1  <= c_d;
			r_s1  <= r_d;
		end
	end

	// ---------------- stage 2: determinant, R.d1 and R.d2
	logic signed [2*CW-1:0]  cc_d;
	logic [2*AW-1:0]         ab_d;
	logic signed [DETW:0]    det_d;
	logic signed [RW+DW-1:0] rd1 [3], rd2 [3];
	logic signed [EW-1:0]    dd_d, ee_d;

	always_comb begin
		cc_d  = c_s1 * c_s1;
		ab_d  = a_s1 * b_s1;
		det_d = $signed((DETW + 1)'(cc_d) - (DETW + 1)'(ab_d));
		for (int k = 0; k < 3; k++) begin
			rd1[k] = r_s1[k] * $signed(ln_s1.d1[k]);
			rd2[k] = r_s1[k] * $signed(ln_s1.d2[k]);
		end
		dd_d = EW'(rd1[0]) + EW'(rd1[1]) + EW'(rd1[2]);
		ee_d = EW'(rd2[0]) + EW'(rd2[1]) + EW'(rd2[2]);
	end

	lines_t               ln_s2;
	logic [AW-1:0]        a_s2, b_s2;
	logic signed [CW-1:0] c_s2;
	logic signed [DETW:0] det_s2;
	logic signed [EW-1:0] dd_s2, ee_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s2  <= ln_s1;
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			c_s2   <= c_s1;
			det_s2 <= det_d;
			dd_s2  <= dd_d;
			ee_s2  <= ee_d;
		end
	end

	// ---------------- stage 3: numerator partial products
	logic signed [XW-1:0] xa, xb, xc;

	always_comb begin
		xa = {1'b0, a_s2};
		xb = {1'b0, b_s2};
		xc = c_s2;
	end

	lines_t                ln_s3;
	logic signed [DETW:0]  det_s3;
	logic signed [PPW-1:0] bdl_s3, bdh_s3, cel_s3, ceh_s3;
	logic signed [PPW-1:0] cdl_s3, cdh_s3, ael_s3, aeh_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s3  <= ln_s2;
			det_s3 <= det_s2;
			bdl_s3 <= mul_xy(xb, ylo(dd_s2));
			bdh_s3 <= mul_xy(xb, yhi(dd_s2));
			cel_s3 <= mul_xy(xc, ylo(ee_s2));
			ceh_s3 <= mul_xy(xc, yhi(ee_s2));
			cdl_s3 <= mul_xy(xc, ylo(dd_s2));
			cdh_s3 <= mul_xy(xc, yhi(dd_s2));
			ael_s3 <= mul_xy(xa, ylo(ee_s2));
			aeh_s3 <= mul_xy(xa, yhi(ee_s2));
		end
	end

	// ---------------- stage 4: numerators, divisor magnitude
	logic signed [NW-1:0] n1_d, n2_d;
	logic signed [DETW:0] ndet;

	always_comb begin
		n1_d = (NW'(bdh_s3) <<< EL) + NW'(bdl_s3)
		       - (NW'(ceh_s3) <<< EL) - NW'(cel_s3);
		n2_d = (NW'(cdh_s3) <<< EL) + NW'(cdl_s3)
		       - (NW'(aeh_s3) <<< EL) - NW'(ael_s3);
		ndet = -det_s3;
	end

	lines_t               ln_s4;
	logic signed [NW-1:0] n1_s4, n2_s4;
	logic [DETW-1:0]      dvs_s4;
	logic                 par_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s4  <= ln_s3;
			n1_s4  <= n1_d;
			n2_s4  <= n2_d;
			dvs_s4 <= ndet[DETW-1:0];
			par_s4 <= (det_s3 == '0);
		end
	end

	// ---------------- stage 5: numerator magnitudes into the divider chain
	logic [NW-1:0] m1, m2;
	div_t          d_d;

	always_comb begin
		m1 = n1_s4[NW-1] ? -n1_s4 : n1_s4;
		m2 = n2_s4[NW-1] ? -n2_s4 : n2_s4;
		d_d.par  = par_s4;
		d_d.neg1 = n1_s4[NW-1];
		d_d.neg2 = n2_s4[NW-1];
		d_d.ln   = ln_s4;
		d_d.dvs  = dvs_s4;
		d_d.rem1 = '0;
		d_d.rem2 = '0;
		d_d.w1   = {m1[NW-2:0], {UP{1'b0}}};
		d_d.w2   = {m2[NW-2:0], {UP{1'b0}}};
	end

	div_t d_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s5 <= d_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvld_q <= '0;
		end else if (en) begin
			fvld_q <= {fvld_q[3:0], s_tvalid};
		end
	end

	// ---------------- divider chain
	div_t dch [QW+1];
	logic dvl [QW+1];

	assign dch[0] = d_s5;
	assign dvl[0] = fvld_q[4];

	for (genvar i = 0; i < QW; i++) begin : g_div
		tlca_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (dvl[i]),
			.din    (dch[i]),
			.vout   (dvl[i+1]),
			.dout   (dch[i+1])
		);
	end

	// ---------------- stage 6: signed line parameters
	// The determinant is never positive, so t has the opposite sign of its numerator.
	logic signed [TW-1:0] tq1, tq2;

	always_comb begin
		tq1 = {1'b0, dch[QW].w1};
		tq2 = {1'b0, dch[QW].w2};
	end

	lines_t               ln_s6;
	logic                 par_s6;
	logic signed [TW-1:0] t1_s6, t2_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s6  <= dch[QW].ln;
			par_s6 <= dch[QW].par;
			t1_s6  <= dch[QW].neg1 ? tq1 : -tq1;
			t2_s6  <= dch[QW].neg2 ? tq2 : -tq2;
		end
	end

	// ---------------- stage 7: t * d in chunks
	lines_t                ln_s7;
	logic                  par_s7;
	logic signed [PDW-1:0] pa_s7 [3][4], pb_s7 [3][4];

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s7  <= ln_s6;
			par_s7 <= par_s6;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 4; j++) begin
					pa_s7[k][j] <= chunk(t1_s6, j) * $signed(ln_s6.d1[k]);
					pb_s7[k][j] <= chunk(t2_s6, j) * $signed(ln_s6.d2[k]);
				end
			end
		end
	end

	// ---------------- stage 8: partial sums of the closest points
	logic                  par_s8;
	logic signed [QVW-1:0] qa1_s8 [3], qb1_s8 [3], qa2_s8 [3], qb2_s8 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			par_s8 <= par_s7;
			for (int k = 0; k < 3; k++) begin
				qa1_s8[k] <= QVW'(pa_s7[k][0]) + (QVW'(pa_s7[k][1]) <<< CK);
				qb1_s8[k] <= (QVW'(pa_s7[k][2]) <<< (2 * CK))
				             + (QVW'(pa_s7[k][3]) <<< (3 * CK))
				             + (QVW'($signed(ln_s7.p1[k])) <<< UP);
				qa2_s8[k] <= QVW'(pb_s7[k][0]) + (QVW'(pb_s7[k][1]) <<< CK);
				qb2_s8[k] <= (QVW'(pb_s7[k][2]) <<< (2 * CK))
				             + (QVW'(pb_s7[k][3]) <<< (3 * CK))
				             + (QVW'($signed(ln_s7.p2[k])) <<< UP);
			end
		end
	end

	// ---------------- stage 9: closest points Q1 and Q2
	logic                  par_s9;
	logic signed [QVW-1:0] q1_s9 [3], q2_s9 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			par_s9 <= par_s8;
			for (int k = 0; k < 3; k++) begin
				q1_s9[k] <= qa1_s8[k] + qb1_s8[k];
				q2_s9[k] <= qa2_s8[k] + qb2_s8[k];
			end
		end
	end

	// ---------------- stage 10: sum and difference
	logic                  par_s10;
	logic signed [QSW-1:0] qs_s10 [3], df_s10 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			par_s10 <= par_s9;
			for (int k = 0; k < 3; k++) begin
				qs_s10[k] <= QSW'(q1_s9[k]) + QSW'(q2_s9[k]);
				df_s10[k] <= QSW'(q1_s9[k]) - QSW'(q2_s9[k]);
			end
		end
	end

	// ---------------- stage 11: vertex shift toward zero, |Q1 - Q2|
	logic [QSW-1:0] vsum [3], dmag [3];
	logic [2:0]     big_d;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			// A negative sum gets a bias so the shift truncates toward zero.
			vsum[k]  = qs_s10[k] + QSW'({VSH{qs_s10[k][QSW-1]}});
			dmag[k]  = df_s10[k][QSW-1] ? -df_s10[k] : df_s10[k];
			big_d[k] = |dmag[k][QSW-1:DLW];
		end
	end

	logic                  par_s11, big_s11;
	logic signed [VQW-1:0] vq_s11 [3];
	logic [DLW-1:0]        dl_s11 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			par_s11 <= par_s10;
			big_s11 <= |big_d;
			for (int k = 0; k < 3; k++) begin
				vq_s11[k] <= vsum[k][QSW-1:VSH];
				dl_s11[k] <= dmag[k][DLW-1:0];
			end
		end
	end

	// ---------------- stage 12: vertex saturation, square partial products
	logic               par_s12, big_s12;
	logic [2:0][PW-1:0] vtx_s12;
	logic [2*DHW-1:0]   hh_s12 [3];
	logic [DLW-1:0]     hl_s12 [3];
	logic [2*DLH-1:0]   ll_s12 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			par_s12 <= par_s11;
			big_s12 <= big_s11;
			for (int k = 0; k < 3; k++) begin
				if (vq_s11[k] > VMAX) begin
					vtx_s12[k] <= VMAX[PW-1:0];
				end else if (vq_s11[k] < VMIN) begin
					vtx_s12[k] <= VMIN[PW-1:0];
				end else begin
					vtx_s12[k] <= vq_s11[k][PW-1:0];
				end
				hh_s12[k] <= dl_s11[k][DLW-1:DLH] * dl_s11[k][DLW-1:DLH];
				hl_s12[k] <= dl_s11[k][DLW-1:DLH] * dl_s11[k][DLH-1:0];
				ll_s12[k] <= dl_s11[k][DLH-1:0] * dl_s11[k][DLH-1:0];
			end
		end
	end

	// ---------------- stage 13: squares of the difference
	logic               par_s13, big_s13;
	logic [2:0][PW-1:0] vtx_s13;
	logic [2*DLW-1:0]   sq_s13 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			par_s13 <= par_s12;
			big_s13 <= big_s12;
			vtx_s13 <= vtx_s12;
			for (int k = 0; k < 3; k++) begin
				sq_s13[k] <= ((2 * DLW)'(hh_s12[k]) << (2 * DLH))
				             + ((2 * DLW)'(hl_s12[k]) << (DLH + 1))
				             + (2 * DLW)'(ll_s12[k]);
			end
		end
	end

	// ---------------- stage 14: squared distance
	logic               par_s14, big_s14;
	logic [2:0][PW-1:0] vtx_s14;
	logic [SW-1:0]      sum_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			par_s14 <= par_s13;
			big_s14 <= big_s13;
			vtx_s14 <= vtx_s13;
			sum_s14 <= SW'(sq_s13[0]) + SW'(sq_s13[1]) + SW'(sq_s13[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvld_q <= '0;
		end else if (en) begin
			bvld_q <= {bvld_q[7:0], dvl[QW]};
		end
	end

	// ---------------- square root chain
	sqr_t sch [PW+1];
	logic svl [PW+1];

	always_comb begin
		sch[0].par  = par_s14;
		sch[0].sat  = big_s14 | (|sum_s14[SW-1:2*UP+SQIN]);
		sch[0].vtx  = vtx_s14;
		sch[0].x    = sum_s14[2*UP +: SQIN];
		sch[0].rem  = '0;
		sch[0].root = '0;
	end

	assign svl[0] = bvld_q[8];

	for (genvar i = 0; i < PW; i++) begin : g_sqrt
		tlca_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (svl[i]),
			.din    (sch[i]),
			.vout   (svl[i+1]),
			.dout   (sch[i+1])
		);
	end

	// ---------------- output register and skid stage
	res_t res_d;

	always_comb begin
		res_d.par = sch[PW].par;
		if (sch[PW].par) begin
			res_d.vtx      = '0;
			res_d.distance = '0;
		end else begin
			res_d.vtx      = sch[PW].vtx;
			res_d.distance = sch[PW].sat ? '1 : sch[PW].root;
		end
	end

	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic take_new, to_skid;

	assign en       = !skid_valid_q;
	assign s_tready = en;
	assign take_new = en && svl[PW] && (!out_valid_q || m_tready);
	assign to_skid  = en && svl[PW] && out_valid_q && !m_tready;

	always_ff @(posedge clk) begin
		if (take_new) begin
			out_q <= res_d;
		end else if (skid_valid_q && m_tready) begin
			out_q <= skid_q;
		end
		if (to_skid) begin
			skid_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take_new) begin
				out_valid_q <= 1'b1;
			end else if (skid_valid_q && m_tready) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (to_skid) begin
				skid_valid_q <= 1'b1;
			end else if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.distance, out_q.vtx};
	assign m_tuser  = out_q.par;

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Two-line closest approach unit testbench
// Feeds line pairs over the input stream and compares each vertex, distance
// and parallel flag with the value that a directed row gives, else with a
// wide-integer predictor of the closest approach. A short directed table comes
// first, then random pairs, with random stalls on both sides but for the last 150 random pairs.
// ----------------------------------------------------------------------------
module testbench import tlca_pkg::*; ();

	typedef logic signed [511:0] huge_t;

	typedef struct {
		logic signed [PW-1:0] p1 [3];
		logic signed [DW-1:0] d1 [3];
		logic signed [PW-1:0] p2 [3];
		logic signed [DW-1:0] d2 [3];
	} line_pair_t;

	typedef struct {
		logic [2:0][PW-1:0] vtx;
		logic [PW-1:0]      distance;
		logic               par;
	} approach_t;

	typedef struct {
		line_pair_t lp;
		logic       known;
		approach_t  res;
	} stim_row_t;

	localparam int N_RANDOM = 1430;
	localparam int TAIL     = 200;
	localparam int LIMIT    = 600000;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;

	approach_t  expected_q [$];
	stim_row_t  dir_rows [$];
	int         mismatches = 0;
	int         cycles = 0;
	bit         calm = 0;
	int         rx_stall = 0;

	two_line_closest_approach_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// The first field sits in the lowest bits of tdata.
	function automatic logic [IN_W-1:0] pack_pair(line_pair_t lp);
		lines_t w;
		for (int k = 0; k < 3; k++) begin
			w.p1[k] = lp.p1[k];
			w.d1[k] = lp.d1[k];
			w.p2[k] = lp.p2[k];
			w.d2[k] = lp.d2[k];
		end
		return {w.d2, w.p2, w.d1, w.p1};
	endfunction

	// Exact closest approach; shifts of signed values are done as divisions
	// so that they truncate toward zero.
	function automatic approach_t closest_approach(line_pair_t lp);
		approach_t r;
		huge_t a, b, c, det, d, e, n1, n2, t1, t2, q1, q2, s, sum, x, sq;
		huge_t maxp, minp;
		logic [PW-1:0] root, cand;
		a = 0; b = 0; c = 0; d = 0; e = 0; sum = 0;
		maxp = (huge_t'(1) <<< (PW - 1)) - 1;
		minp = -(huge_t'(1) <<< (PW - 1));
		for (int k = 0; k < 3; k++) begin
			a += huge_t'(lp.d1[k]) * huge_t'(lp.d1[k]);
			b += huge_t'(lp.d2[k]) * huge_t'(lp.d2[k]);
			c += huge_t'(lp.d1[k]) * huge_t'(lp.d2[k]);
		end
		det = c * c - a * b;
		r.vtx = '0;
		r.distance = '0;
		r.par = 1'b1;
		if (det == 0)
			return r;
		r.par = 1'b0;
		for (int k = 0; k < 3; k++) begin
			d += (huge_t'(lp.p1[k]) - huge_t'(lp.p2[k])) * huge_t'(lp.d1[k]);
			e += (huge_t'(lp.p1[k]) - huge_t'(lp.p2[k])) * huge_t'(lp.d2[k]);
		end
		n1 = b * d - c * e;
		n2 = c * d - a * e;
		t1 = (n1 * (huge_t'(1) <<< UP)) / det;
		t2 = (n2 * (huge_t'(1) <<< UP)) / det;
		for (int k = 0; k < 3; k++) begin
			q1 = huge_t'(lp.p1[k]) * (huge_t'(1) <<< UP) + t1 * huge_t'(lp.d1[k]);
			q2 = huge_t'(lp.p2[k]) * (huge_t'(1) <<< UP) + t2 * huge_t'(lp.d2[k]);
			s = (q1 + q2) / (huge_t'(1) <<< (UP + 1));
			if (s > maxp) s = maxp;
			if (s < minp) s = minp;
			r.vtx[k] = s[PW-1:0];
			sum += (q1 - q2) * (q1 - q2);
		end
		x = sum / (huge_t'(1) <<< (2 * UP));
		if (x >= (huge_t'(1) <<< (2 * PW))) begin
			r.distance = '1;
		end else begin
			root = '0;
			for (int i = PW - 1; i >= 0; i--) begin
				cand = root | (PW'(1) << i);
				sq = huge_t'({1'b0, cand}) * huge_t'({1'b0, cand});
				if (sq <= x)
					root = cand;
			end
			r.distance = root;
		end
		return r;
	endfunction

	function automatic logic signed [PW-1:0] rand_point(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed(PW'($urandom_range(0, 8191))) - 4096;
			default: return $urandom_range(0, 1) ? {1'b0, {(PW-1){1'b1}}}
			                                     : {1'b1, {(PW-1){1'b0}}};
		endcase
	endfunction

	function automatic logic signed [DW-1:0] rand_dir(int mode);
		case (mode)
			0: return DW'($urandom);
			1: return DW'($signed(DW'($urandom_range(0, 15))) - 8);
			default: return $urandom_range(0, 1) ? {1'b0, {(DW-1){1'b1}}}
			                                     : {1'b1, {(DW-1){1'b0}}};
		endcase
	endfunction

	function automatic line_pair_t random_pair();
		line_pair_t lp;
		int pm, dm, kind;
		int signed f;
		pm = $urandom_range(0, 9) < 7 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
		dm = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 2) == 0 ? 2 : 1);
		kind = $urandom_range(0, 9);
		for (int k = 0; k < 3; k++) begin
			lp.p1[k] = rand_point(pm);
			lp.p2[k] = rand_point(pm);
			lp.d1[k] = rand_dir(dm);
			lp.d2[k] = rand_dir(dm);
		end
		// Some pairs are made parallel on purpose: a scaled copy of one direction.
		if (kind == 0) begin
			f = $signed($urandom_range(0, 6)) - 3;
			for (int k = 0; k < 3; k++) begin
				lp.d1[k] = rand_dir(1);
				lp.d2[k] = DW'(lp.d1[k] * f);
			end
		end
		return lp;
	endfunction

	function automatic stim_row_t mk_row(
		input int p1x, p1y, p1z, d1x, d1y, d1z,
		input int p2x, p2y, p2z, d2x, d2y, d2z,
		input logic known, input int vx, vy, vz, input logic [PW-1:0] distance,
		input logic par
	);
		stim_row_t row;
		row.lp.p1[0] = p1x; row.lp.p1[1] = p1y; row.lp.p1[2] = p1z;
		row.lp.d1[0] = DW'(d1x); row.lp.d1[1] = DW'(d1y); row.lp.d1[2] = DW'(d1z);
		row.lp.p2[0] = p2x; row.lp.p2[1] = p2y; row.lp.p2[2] = p2z;
		row.lp.d2[0] = DW'(d2x); row.lp.d2[1] = DW'(d2y); row.lp.d2[2] = DW'(d2z);
		row.known = known;
		row.res.vtx[0] = vx; row.res.vtx[1] = vy; row.res.vtx[2] = vz;
		row.res.distance = distance;
		row.res.par = par;
		return row;
	endfunction

	// Sends one pair, with a random gap before it unless the run is calm.
	task automatic send_pair(input line_pair_t lp, input logic known, input approach_t res);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pack_pair(lp);
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(known ? res : closest_approach(lp));
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result checker and receiver stall generator.
	always @(posedge clk) begin
		approach_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: data=%h parallel=%b", m_tdata, m_tuser);
			end else begin
				want = expected_q.pop_front();
				if (m_tdata !== {want.distance, want.vtx} || m_tuser !== want.par) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected vtx=%h,%h,%h dist=%h par=%b, ",
							"got vtx=%h,%h,%h dist=%h par=%b"},
							want.vtx[0], want.vtx[1], want.vtx[2], want.distance, want.par,
							m_tdata[PW-1:0], m_tdata[2*PW-1:PW], m_tdata[3*PW-1:2*PW],
							m_tdata[4*PW-1:3*PW], m_tuser);
				end
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			rx_stall <= $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		approach_t none;
		line_pair_t lp;
		none = '{vtx: '0, distance: '0, par: 1'b0};
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;

		// All zero: no direction at all counts as parallel.
		dir_rows.push_back(mk_row(0,0,0, 0,0,0, 0,0,0, 0,0,0, 1, 0,0,0, 0, 1));
		// Same direction, different points: parallel.
		dir_rows.push_back(mk_row(256,0,0, 1,0,0, 0,512,0, 1,0,0, 1, 0,0,0, 0, 1));
		// Opposite scaled direction: parallel.
		dir_rows.push_back(mk_row(5,6,7, 3,-2,1, -9,8,0, -6,4,-2, 1, 0,0,0, 0, 1));
		// Largest directions, parallel with opposite sign.
		dir_rows.push_back(mk_row(-2147483648,2147483647,0, -32768,-32768,-32768,
			2147483647,-2147483648,0, 32767,32767,32767, 0, 0,0,0, 0, 0));
		// Perpendicular axes offset by one unit in z.
		dir_rows.push_back(mk_row(0,0,256, 1,0,0, 0,0,0, 0,1,0, 1, 0,0,128, 256, 0));
		// Same axes with the offset reversed.
		dir_rows.push_back(mk_row(0,0,-256, 1,0,0, 0,0,0, 0,1,0, 1, 0,0,-128, 256, 0));
		// Point extremes on perpendicular axes.
		dir_rows.push_back(mk_row(2147483647,2147483647,2147483647, 1,0,0,
			-2147483648,-2147483648,-2147483648, 0,1,0, 0, 0,0,0, 0, 0));
		dir_rows.push_back(mk_row(-2147483648,-2147483648,2147483647, 0,0,1,
			2147483647,2147483647,-2147483648, 1,1,0, 0, 0,0,0, 0, 0));
		// Direction extremes.
		dir_rows.push_back(mk_row(100,-200,300, 32767,0,0, -400,500,-600, 0,-32768,0,
			0, 0,0,0, 0, 0));
		dir_rows.push_back(mk_row(1,1,1, 32767,-32768,1, -1,-1,-1, -32768,32767,1,
			0, 0,0,0, 0, 0));
		// Nearly parallel lines drive the parameters and the vertex far out; the last row is perpendicular.
		dir_rows.push_back(mk_row(2147483647,0,0, 32767,32766,0,
			-2147483648,0,256, 32766,32765,0, 0, 0,0,0, 0, 0));
		dir_rows.push_back(mk_row(0,2147483647,-2147483648, 1,2,3,
			0,-2147483648,2147483647, 2,4,7, 0, 0,0,0, 0, 0));
		dir_rows.push_back(mk_row(-7,8,-9, 0,0,-1, 10,-11,12, 0,-1,0, 0, 0,0,0, 0, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_pair(dir_rows[i].lp, dir_rows[i].known, dir_rows[i].res);

		// Hold the sender until the pipeline has drained once.
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - 150)
				calm = 1;
			lp = random_pair();
			send_pair(lp, 1'b0, none);
		end
		s_tvalid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
